### rtl/core/mpdp_pkg.sv
package mpdp_pkg;

  localparam int unsigned ACT_BITS   = 4;
  localparam int unsigned WT_BITS    = 2;
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned ACT_W      = 32;
  localparam int unsigned WT_W       = 16;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned BIAS_W     = 8;
  // lanes that physically fit in the packed words
  localparam int unsigned PACK_LANES = 8;
  localparam int unsigned PROD_W     = 7;
  localparam int unsigned SUM_W      = 10;

  localparam logic [ACT_BITS-1:0] ACT_MASK = 4'hf;

  typedef struct packed {
    logic [ACT_W-1:0]  act_word;
    logic [WT_W-1:0]   weight_word;
    logic [CNT_W-1:0]  lane_count;
    logic [BIAS_W-1:0] bias_value;
    logic              row_first;
    logic              row_last;
  } mpdp_item_t;

  // unsigned 4-bit activation times signed 2-bit weight
  function automatic logic signed [PROD_W-1:0] lane_product(
    input logic [ACT_BITS-1:0] act,
    input logic [WT_BITS-1:0]  wt
  );
    logic signed [PROD_W-1:0] av;
    logic signed [PROD_W-1:0] wv;
    av = $signed({{(PROD_W-ACT_BITS){1'b0}}, act & ACT_MASK});
    wv = $signed({{(PROD_W-WT_BITS){wt[WT_BITS-1]}}, wt});
    return av * wv;
  endfunction

endpackage

### rtl/core/mixed_precision_dot_product_core.sv
// A result passes the input register and then the result register after its last item is accepted.
// Throughput: one item per cycle while in_stall is low; the accumulator update needs no extra stage.
// The input stage stalls only when it holds a last item and the result register is stalled.
// Reset (rst_n low, synchronous): clears stage valids, the accumulator and bias_enable.
module mixed_precision_dot_product_core
  import mpdp_pkg::*;
#(
  parameter int unsigned LANES = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_bias_enable,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ACT_W-1:0]         in_act_word,
  input  logic [WT_W-1:0]          in_weight_word,
  input  logic [CNT_W-1:0]         in_lane_count,
  input  logic signed [BIAS_W-1:0] in_bias_value,
  input  logic                     in_row_first,
  input  logic                     in_row_last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ACC_W-1:0]  out_neuron_sum
);

  logic             bias_enable_r;
  logic             s1_valid_r;
  mpdp_item_t       s1_item_r;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [ACC_W-1:0] out_sum_r;
  logic             s1_adv;
  logic             in_take;
  logic signed [SUM_W-1:0] dot;
  logic [ACC_W-1:0] acc_base;

  assign cfg_ready = 1'b1;

  // a non-last item never waits on the result side
  assign s1_adv   = s1_valid_r && (!s1_item_r.row_last || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    logic signed [PROD_W-1:0] p;
    dot = '0;
    for (int k = 0; k < PACK_LANES; k++) begin
      p = lane_product(s1_item_r.act_word[k*ACT_BITS +: ACT_BITS],
                       s1_item_r.weight_word[k*WT_BITS +: WT_BITS]);
      if ((k < LANES) && (CNT_W'(k) < s1_item_r.lane_count)) begin
        dot = dot + {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
      end
    end
  end

  always_comb begin
    if (s1_item_r.row_first) begin
      acc_base = bias_enable_r
               ? {{(ACC_W-BIAS_W){s1_item_r.bias_value[BIAS_W-1]}}, s1_item_r.bias_value}
               : '0;
    end else begin
      acc_base = acc_r;
    end
    acc_nxt = acc_base + {{(ACC_W-SUM_W){dot[SUM_W-1]}}, dot};
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (s1_adv && s1_item_r.row_last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_enable_r <= 1'b0;
      s1_valid_r    <= 1'b0;
      acc_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bias_enable_r <= cfg_bias_enable;
      end
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        acc_r <= acc_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.act_word    <= in_act_word;
      s1_item_r.weight_word <= in_weight_word;
      s1_item_r.lane_count  <= in_lane_count;
      s1_item_r.bias_value  <= in_bias_value;
      s1_item_r.row_first   <= in_row_first;
      s1_item_r.row_last    <= in_row_last;
    end
    if (s1_adv && s1_item_r.row_last) begin
      out_sum_r <= acc_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_neuron_sum = $signed(out_sum_r);

endmodule

### rtl/core/mpdp_checker.sv
module mpdp_props
  import mpdp_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     cfg_valid,
  input logic                     cfg_ready,
  input logic                     cfg_bias_enable,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [ACT_W-1:0]         in_act_word,
  input logic [WT_W-1:0]          in_weight_word,
  input logic [CNT_W-1:0]         in_lane_count,
  input logic signed [BIAS_W-1:0] in_bias_value,
  input logic                     in_row_first,
  input logic                     in_row_last,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [ACC_W-1:0]  out_neuron_sum
);

  // result register holds while the sink stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_neuron_sum))
    else $error("result changed while stalled");

  // reset empties the result side
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input backpressure comes only from a stalled, full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without result backpressure");

  // a fresh result needs an earlier accepted last item, passed through the input register
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_row_last, 2))
    else $error("result without a last item");

endmodule

bind mixed_precision_dot_product_core mpdp_props u_mpdp_props (.*);
